@@ rtl/core/stbs_pkg.sv @@
`timescale 1ns / 1ps
package stbs_pkg;

  localparam int KEY_W = 64;
  localparam int IDX_W = 10;
  localparam int POS_W = 10;
  localparam int CNT_W = 11;
  localparam int FUNC_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_WRITE = 2'd0,
    FN_LOWER = 2'd1,
    FN_UPPER = 2'd2,
    FN_LAST  = 2'd3
  } func_t;

  // controller -> datapath
  typedef struct packed {
    logic write;   // table write word accepted
    logic load;    // query word accepted, set up search window
    logic probe;   // one halving step
    logic report;  // form result word
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cnt_zero;   // no entries in use
    logic last_probe; // window closes on this step
  } status_t;

endpackage

@@ rtl/core/sorted_table_bound_search_top.sv @@
`timescale 1ns / 1ps
// Binary search over a table of signed 64-bit entries kept in ascending order.
// A word is taken when start is high and busy is low. A table write (func 0)
// completes at that edge and busy stays low. A query holds busy while it
// probes, at most floor(log2(n))+1 probes for n entries in use, and while it
// forms the result; the single read port of the table RAM allows one probe
// per cycle. The result word appears on out_found/out_position with out_valid
// high for exactly one cycle, the cycle in which busy falls; the receiver
// cannot stall, so it must take the word then. A new word may be started in
// that same cycle. entry_count may be written only while busy is low and no
// result is pending.
module sorted_table_bound_search_top
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [IDX_W-1:0]  in_entry_index,
  input  logic [KEY_W-1:0]  in_value,
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,
  output logic              out_valid,
  output logic              out_found,
  output logic [POS_W-1:0]  out_position
);

  cmd_t    cmd;
  status_t status;

  stbs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  stbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_func        (in_func),
    .in_entry_index (in_entry_index),
    .in_value       (in_value),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_valid      (out_valid),
    .out_found      (out_found),
    .out_position   (out_position)
  );

endmodule

@@ rtl/core/stbs_ram.sv @@
`timescale 1ns / 1ps
module stbs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/stbs_ctrl.sv @@
`timescale 1ns / 1ps
module stbs_ctrl
  import stbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [FUNC_W-1:0] in_func,
  input  status_t           status,
  output cmd_t              cmd,
  output logic              busy
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_PROBE  = 3'b010,
    ST_REPORT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_func == FN_WRITE) begin
            cmd.write = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = status.cnt_zero ? ST_REPORT : ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        cmd.probe = 1'b1;
        if (status.last_probe) begin
          state_nxt = ST_REPORT;
        end
      end
      ST_REPORT: begin
        cmd.report = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

@@ rtl/core/stbs_dp.sv @@
`timescale 1ns / 1ps
module stbs_dp
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output status_t           status,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [IDX_W-1:0]  in_entry_index,
  input  logic [KEY_W-1:0]  in_value,
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,
  output logic              out_valid,
  output logic              out_found,
  output logic [POS_W-1:0]  out_position
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int XW = CW + CNT_W;
  localparam int IW = CW + IDX_W;

  logic [CNT_W-1:0]  cfg_count_r;
  logic [CW-1:0]     lo_r, lo_nxt;
  logic [CW-1:0]     hi_r, hi_nxt;
  logic [CW-1:0]     mid_r, mid_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic              out_valid_r;
  logic              out_found_r, out_found_nxt;
  logic [POS_W-1:0]  out_position_r, out_position_nxt;

  logic [XW-1:0]     cnt_x;
  logic [XW-1:0]     depth_x;
  logic [CW-1:0]     n_new;
  logic [IW-1:0]     idx_x;
  logic              wr_ok;
  logic              rd_en;
  logic [KEY_W-1:0]  rd_data;
  logic              go_right;
  logic [CW-1:0]     lo_step, hi_step;
  logic              probe_last;
  logic [CW-1:0]     pos_full;
  logic [CW+POS_W-1:0] pos_x;

  // clamp the in-use count to the table size
  assign cnt_x   = XW'(cfg_count_r);
  assign depth_x = XW'(TABLE_DEPTH);
  assign n_new   = (cnt_x > depth_x) ? depth_x[CW-1:0] : cnt_x[CW-1:0];

  assign idx_x = IW'(in_entry_index);
  assign wr_ok = cmd.write && (idx_x < IW'(TABLE_DEPTH));

  // signed compare against the entry read for mid_r
  always_comb begin
    if (func_r == FN_LOWER) begin
      go_right = $signed(rd_data) < $signed(key_r);
    end else begin
      go_right = !($signed(key_r) < $signed(rd_data));
    end
    lo_step    = go_right ? CW'(mid_r + 1'b1) : lo_r;
    hi_step    = go_right ? hi_r : mid_r;
    probe_last = (lo_step >= hi_step);
  end

  assign status.cnt_zero   = (cfg_count_r == '0);
  assign status.last_probe = probe_last;

  always_comb begin
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    mid_nxt  = mid_r;
    n_nxt    = n_r;
    key_nxt  = key_r;
    func_nxt = func_r;
    rd_en    = 1'b0;
    if (cmd.load) begin
      lo_nxt   = '0;
      hi_nxt   = n_new;
      mid_nxt  = n_new >> 1;
      n_nxt    = n_new;
      key_nxt  = in_value;
      func_nxt = in_func;
      rd_en    = 1'b1;
    end else if (cmd.probe) begin
      lo_nxt  = lo_step;
      hi_nxt  = hi_step;
      mid_nxt = CW'(lo_step + ((hi_step - lo_step) >> 1));
      rd_en   = !probe_last;
    end
  end

  // lo_r holds the bound; last-not-greater steps back one
  always_comb begin
    if (func_r == FN_LAST) begin
      out_found_nxt = (lo_r != '0);
      pos_full      = CW'(lo_r - 1'b1);
    end else begin
      out_found_nxt = (lo_r < n_r);
      pos_full      = lo_r;
    end
    pos_x            = (CW + POS_W)'(pos_full);
    out_position_nxt = out_found_nxt ? pos_x[POS_W-1:0] : '0;
  end

  stbs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (idx_x[AW-1:0]),
    .wdata (in_value),
    .re    (rd_en),
    .raddr (mid_nxt[AW-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_count_r <= cfg_wr_data;
      end
      out_valid_r <= cmd.report;
    end
  end

  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    n_r    <= n_nxt;
    key_r  <= key_nxt;
    func_r <= func_nxt;
    if (cmd.report) begin
      out_found_r    <= out_found_nxt;
      out_position_r <= out_position_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;

endmodule

@@ rtl/core/stbs_chk.sv @@
`timescale 1ns / 1ps
module stbs_chk
  import stbs_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic [FUNC_W-1:0] in_func,
  input logic              out_valid,
  input logic              out_found,
  input logic [POS_W-1:0]  out_position
);

  // a query always occupies the block
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func != FN_WRITE) |=> busy)
    else $error("query word did not raise busy");

  // a table write never occupies the block
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == FN_WRITE) |=> !busy)
    else $error("table write raised busy");

  // result word only after the search has ended
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $fell(busy)))
    else $error("result word while busy or without a search");

  a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_position == '0))
    else $error("miss result carries nonzero position");

endmodule

bind sorted_table_bound_search_top stbs_chk u_stbs_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_func      (in_func),
  .out_valid    (out_valid),
  .out_found    (out_found),
  .out_position (out_position)
);
